// ===== rtl/core/pidfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types, constants and arithmetic helpers shared by the PID controller files.
// ----------------------------------------------------------------------------
package pidfd_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

	localparam logic signed [15:0] GAIN_P_RESET = 16'sd2560;
	localparam logic signed [15:0] GAIN_I_RESET = 16'sd0;
	localparam logic signed [15:0] GAIN_D_RESET = 16'sd0;
	localparam logic [19:0] TIMEOUT_RESET = 20'd20000;

	localparam logic signed [31:0] DRIVE_LIMIT = 32'sd25600;
	localparam logic signed [47:0] DIFF_SCALE = 48'sd200000;

	// Division by one million is a shift by six followed by a division by
	// 15625; both constant divisions use a reciprocal that is at most one low.
	localparam logic [19:0] MEGA_HALF = 20'd500000;
	localparam int unsigned MEGA_SHIFT = 6;
	localparam logic [13:0] MEGA_RED = 14'd15625;
	localparam logic [31:0] MEGA_RECIP = 32'd35184372;
	localparam int unsigned MEGA_K = 39;
	localparam logic [19:0] FIVE_HALF = 20'd2;
	localparam logic [13:0] FIVE_DIV = 14'd5;
	localparam logic [31:0] FIVE_RECIP = 32'd3435973836;
	localparam int unsigned FIVE_K = 34;

	localparam int unsigned DIV_W = 48;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_TIMEOUT,
		OP_MUL_INT,
		OP_MUL_RATE,
		OP_MUL_DIFF,
		OP_DIV_START,
		OP_TAKE_INT,
		OP_TAKE_R1,
		OP_TAKE_R2,
		OP_COMMIT,
		OP_MUL_GP,
		OP_MUL_GI,
		OP_MUL_GD,
		OP_TERM_FIRST,
		OP_TERM_ADD,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		DEN_MEGA,
		DEN_FIVE,
		DEN_DT
	} den_sel_t;

	typedef struct packed {
		op_t      op;
		den_sel_t den;
	} cmd_t;

	typedef struct packed {
		logic timeout;
		logic dt_zero;
		logic div_done;
		logic out_busy;
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_INT,
		ST_WAIT_INT,
		ST_MUL_RATE,
		ST_DIV_RATE,
		ST_WAIT_RATE,
		ST_MUL_DIFF,
		ST_DIV_DIFF,
		ST_WAIT_DIFF,
		ST_COMMIT,
		ST_MUL_P,
		ST_TERM_P,
		ST_MUL_I,
		ST_TERM_I,
		ST_MUL_D,
		ST_TERM_D,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Divide by 256 rounding to nearest, ties away from zero.
	function automatic logic signed [40:0] rnd256(input logic signed [47:0] x);
		logic [47:0] mag;
		logic [47:0] sum;
		logic [40:0] q;
		mag = x[47] ? 48'(-x) : 48'(x);
		sum = mag + 48'd128;
		q = 41'(sum >> 8);
		return x[47] ? -$signed(q) : $signed(q);
	endfunction

endpackage

// ===== rtl/core/pidfd_div.sv =====
// ----------------------------------------------------------------------------
// pidfd_div
// Divider rounding to nearest: radix-2 restoring for the elapsed-time divisor,
// reciprocal multiplication with a final correction for constant divisors.
// ----------------------------------------------------------------------------
module pidfd_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  pidfd_pkg::den_sel_t                  sel,
	input  logic signed [pidfd_pkg::DIV_W-1:0]   num,
	input  logic [31:0]                          den,
	output logic                                 done,
	output logic signed [pidfd_pkg::DIV_W-1:0]   quo
);

	localparam int unsigned W = pidfd_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W);
	localparam int unsigned RECIP_LAST = 4;

	logic [W-1:0]  quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic          recip_q;
	logic          mega_q;
	logic [38:0]   n_q;
	logic [31:0]   m_q;
	logic [13:0]   d_q;
	logic [51:0]   plo_q;
	logic [50:0]   phi_q;
	logic [46:0]   qd_q;

	logic [W-1:0]  half;
	logic [W-1:0]  mag;
	logic [32:0]   trial;
	logic          fits;
	logic          mega;
	logic [71:0]   sum;
	logic [46:0]   rem;

	always_comb begin
		case (sel)
			pidfd_pkg::DEN_MEGA: half = W'(pidfd_pkg::MEGA_HALF);
			pidfd_pkg::DEN_FIVE: half = W'(pidfd_pkg::FIVE_HALF);
			pidfd_pkg::DEN_DT:   half = W'(den >> 1);
			default:             half = W'(den >> 1);
		endcase
	end

	assign mega = sel == pidfd_pkg::DEN_MEGA;
	assign mag = (num[W-1] ? W'(-num) : W'(num)) + half;
	assign trial = {rem_q, quo_q[W-1]};
	assign fits = trial >= {1'b0, den_q};
	assign sum = 72'(plo_q) + (72'(phi_q) << 20);
	assign rem = 47'(n_q) - qd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			recip_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				recip_q <= sel != pidfd_pkg::DEN_DT;
			end else if (busy_q) begin
				if (recip_q ? cnt_q == CW'(RECIP_LAST) : cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[W-1];
			n_q <= mega ? 39'(mag >> pidfd_pkg::MEGA_SHIFT) : 39'(mag);
			m_q <= mega ? pidfd_pkg::MEGA_RECIP : pidfd_pkg::FIVE_RECIP;
			d_q <= mega ? pidfd_pkg::MEGA_RED : pidfd_pkg::FIVE_DIV;
			mega_q <= mega;
		end else if (busy_q && recip_q) begin
			case (cnt_q)
				CW'(0): plo_q <= 52'(n_q[19:0]) * 52'(m_q);
				CW'(1): phi_q <= 51'(n_q[38:20]) * 51'(m_q);
				CW'(2): quo_q <= mega_q ? W'(sum >> pidfd_pkg::MEGA_K)
					: W'(sum >> pidfd_pkg::FIVE_K);
				CW'(3): qd_q <= 47'(quo_q[32:0]) * 47'(d_q);
				CW'(4): begin
					if (rem >= 47'(d_q)) begin
						quo_q <= quo_q + W'(1);
					end
				end
				default: ;
			endcase
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/core/pidfd_datapath.sv =====
// ----------------------------------------------------------------------------
// pidfd_datapath
// Controller state, configuration, multiplier, divider and output register.
// ----------------------------------------------------------------------------
module pidfd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  pidfd_pkg::cmd_t     cmd,
	output pidfd_pkg::status_t  status,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic signed [23:0]  setpoint,
	input  logic signed [23:0]  measured,
	input  logic [31:0]         now_us,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  drive,
	output logic                updated
);

	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_i_q;
	logic signed [15:0] gain_d_q;
	logic [19:0]        timeout_q;

	logic [31:0]        last_time_q;
	logic signed [24:0] prev_err_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] rate_q;

	logic signed [24:0] e_q;
	logic [31:0]        dt_q;
	logic [31:0]        now_q;
	logic signed [47:0] prod_q;
	logic signed [48:0] acc_q;
	logic signed [31:0] sum_q;

	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic               updated_q;

	logic                div_start;
	logic                div_done;
	logic signed [47:0]  div_quo;
	logic signed [25:0]  diff;
	logic signed [31:0]  term;
	logic signed [15:0]  clamped;

	pidfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sel    (cmd.den),
		.num    (prod_q),
		.den    (dt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign div_start = cmd.op == pidfd_pkg::OP_DIV_START;

	assign diff = 26'(e_q) - 26'(prev_err_q);
	assign term = pidfd_pkg::sat32(50'(pidfd_pkg::rnd256(prod_q)));

	always_comb begin
		if (sum_q > pidfd_pkg::DRIVE_LIMIT) begin
			clamped = 16'(pidfd_pkg::DRIVE_LIMIT);
		end else if (sum_q < -pidfd_pkg::DRIVE_LIMIT) begin
			clamped = 16'(-pidfd_pkg::DRIVE_LIMIT);
		end else begin
			clamped = sum_q[15:0];
		end
	end

	assign status.timeout = dt_q > {12'd0, timeout_q};
	assign status.dt_zero = dt_q == 32'd0;
	assign status.div_done = div_done;
	assign status.out_busy = out_valid_q & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= pidfd_pkg::GAIN_P_RESET;
			gain_i_q <= pidfd_pkg::GAIN_I_RESET;
			gain_d_q <= pidfd_pkg::GAIN_D_RESET;
			timeout_q <= pidfd_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pidfd_pkg::CFG_GAIN_P:  gain_p_q <= cfg_data[15:0];
				pidfd_pkg::CFG_GAIN_I:  gain_i_q <= cfg_data[15:0];
				pidfd_pkg::CFG_GAIN_D:  gain_d_q <= cfg_data[15:0];
				pidfd_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			prev_err_q <= '0;
			integ_q <= '0;
			rate_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == pidfd_pkg::OP_OUT || cmd.op == pidfd_pkg::OP_TIMEOUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				pidfd_pkg::OP_TIMEOUT: begin
					last_time_q <= now_q;
					prev_err_q <= '0;
					integ_q <= '0;
					rate_q <= '0;
				end
				pidfd_pkg::OP_TAKE_INT: begin
					integ_q <= pidfd_pkg::sat32(50'(integ_q) + 50'(div_quo));
				end
				pidfd_pkg::OP_COMMIT: begin
					rate_q <= pidfd_pkg::sat32(50'(acc_q));
					prev_err_q <= e_q;
					last_time_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			pidfd_pkg::OP_LOAD: begin
				e_q <= 25'(setpoint) - 25'(measured);
				dt_q <= now_us - last_time_q;
				now_q <= now_us;
			end
			pidfd_pkg::OP_TIMEOUT: begin
				drive_q <= '0;
				updated_q <= 1'b0;
			end
			pidfd_pkg::OP_MUL_INT: prod_q <= 48'(e_q) * 48'($signed({1'b0, dt_q[19:0]}));
			pidfd_pkg::OP_MUL_RATE: prod_q <= 48'(rate_q) <<< 2;
			pidfd_pkg::OP_MUL_DIFF: prod_q <= 48'(diff) * pidfd_pkg::DIFF_SCALE;
			pidfd_pkg::OP_MUL_GP: prod_q <= 48'(gain_p_q) * 48'(e_q);
			pidfd_pkg::OP_MUL_GI: prod_q <= 48'(gain_i_q) * 48'(integ_q);
			pidfd_pkg::OP_MUL_GD: prod_q <= 48'(gain_d_q) * 48'(rate_q);
			pidfd_pkg::OP_TAKE_R1: acc_q <= 49'(div_quo);
			pidfd_pkg::OP_TAKE_R2: acc_q <= acc_q + 49'(div_quo);
			pidfd_pkg::OP_TERM_FIRST: sum_q <= term;
			pidfd_pkg::OP_TERM_ADD: sum_q <= pidfd_pkg::sat32(50'(sum_q) + 50'(term));
			pidfd_pkg::OP_OUT: begin
				drive_q <= clamped;
				updated_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign updated = updated_q;

endmodule

// ===== rtl/core/pidfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidfd_ctrl
// Sequencer that steps the datapath through one controller update.
// ----------------------------------------------------------------------------
module pidfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pidfd_pkg::status_t  status,
	output pidfd_pkg::cmd_t     cmd
);

	pidfd_pkg::state_t state_q;
	pidfd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = pidfd_pkg::OP_NONE;
		cmd.den = pidfd_pkg::DEN_MEGA;
		in_ready = 1'b0;
		case (state_q)
			pidfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = pidfd_pkg::OP_LOAD;
					state_d = pidfd_pkg::ST_CHECK;
				end
			end
			pidfd_pkg::ST_CHECK: begin
				if (status.timeout) begin
					if (!status.out_busy) begin
						cmd.op = pidfd_pkg::OP_TIMEOUT;
						state_d = pidfd_pkg::ST_IDLE;
					end
				end else begin
					cmd.op = pidfd_pkg::OP_MUL_INT;
					state_d = pidfd_pkg::ST_DIV_INT;
				end
			end
			pidfd_pkg::ST_DIV_INT: begin
				cmd.op = pidfd_pkg::OP_DIV_START;
				cmd.den = pidfd_pkg::DEN_MEGA;
				state_d = pidfd_pkg::ST_WAIT_INT;
			end
			pidfd_pkg::ST_WAIT_INT: begin
				if (status.div_done) begin
					cmd.op = pidfd_pkg::OP_TAKE_INT;
					state_d = pidfd_pkg::ST_MUL_RATE;
				end
			end
			pidfd_pkg::ST_MUL_RATE: begin
				cmd.op = pidfd_pkg::OP_MUL_RATE;
				state_d = pidfd_pkg::ST_DIV_RATE;
			end
			pidfd_pkg::ST_DIV_RATE: begin
				cmd.op = pidfd_pkg::OP_DIV_START;
				cmd.den = pidfd_pkg::DEN_FIVE;
				state_d = pidfd_pkg::ST_WAIT_RATE;
			end
			pidfd_pkg::ST_WAIT_RATE: begin
				if (status.div_done) begin
					cmd.op = pidfd_pkg::OP_TAKE_R1;
					state_d = status.dt_zero ? pidfd_pkg::ST_COMMIT : pidfd_pkg::ST_MUL_DIFF;
				end
			end
			pidfd_pkg::ST_MUL_DIFF: begin
				cmd.op = pidfd_pkg::OP_MUL_DIFF;
				state_d = pidfd_pkg::ST_DIV_DIFF;
			end
			pidfd_pkg::ST_DIV_DIFF: begin
				cmd.op = pidfd_pkg::OP_DIV_START;
				cmd.den = pidfd_pkg::DEN_DT;
				state_d = pidfd_pkg::ST_WAIT_DIFF;
			end
			pidfd_pkg::ST_WAIT_DIFF: begin
				if (status.div_done) begin
					cmd.op = pidfd_pkg::OP_TAKE_R2;
					state_d = pidfd_pkg::ST_COMMIT;
				end
			end
			pidfd_pkg::ST_COMMIT: begin
				cmd.op = pidfd_pkg::OP_COMMIT;
				state_d = pidfd_pkg::ST_MUL_P;
			end
			pidfd_pkg::ST_MUL_P: begin
				cmd.op = pidfd_pkg::OP_MUL_GP;
				state_d = pidfd_pkg::ST_TERM_P;
			end
			pidfd_pkg::ST_TERM_P: begin
				cmd.op = pidfd_pkg::OP_TERM_FIRST;
				state_d = pidfd_pkg::ST_MUL_I;
			end
			pidfd_pkg::ST_MUL_I: begin
				cmd.op = pidfd_pkg::OP_MUL_GI;
				state_d = pidfd_pkg::ST_TERM_I;
			end
			pidfd_pkg::ST_TERM_I: begin
				cmd.op = pidfd_pkg::OP_TERM_ADD;
				state_d = pidfd_pkg::ST_MUL_D;
			end
			pidfd_pkg::ST_MUL_D: begin
				cmd.op = pidfd_pkg::OP_MUL_GD;
				state_d = pidfd_pkg::ST_TERM_D;
			end
			pidfd_pkg::ST_TERM_D: begin
				cmd.op = pidfd_pkg::OP_TERM_ADD;
				state_d = pidfd_pkg::ST_OUT;
			end
			pidfd_pkg::ST_OUT: begin
				if (!status.out_busy) begin
					cmd.op = pidfd_pkg::OP_OUT;
					state_d = pidfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pidfd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/pid_controller_filtered_derivative.sv =====
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative
// Fixed-point PID controller with a low-pass filtered derivative term.
//
// Channel   Direction  Beat contents
// s_axis    in         setpoint, measured, now_us
// m_axis    out        drive, with updated in tuser
// cfg       in         gain_p, gain_i, gain_d, timeout_us
//
// An update runs from one accepted beat until the block is ready again, its
// length set mostly by the radix-2 division by the elapsed time; the
// divisions by one million and by five use reciprocal multiplication. With no
// elapsed time the update skips the radix-2 division, and a timed-out beat
// skips all divisions. The check and output steps hold while an earlier
// result still waits. Reset clears all controller state.
// ----------------------------------------------------------------------------
module pid_controller_filtered_derivative (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // setpoint[23:0], measured[47:24], now_us[79:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // drive[15:0]
	output logic [0:0]  m_tuser,  // updated[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	pidfd_pkg::cmd_t    cmd;
	pidfd_pkg::status_t status;
	logic signed [15:0] drive;

	pidfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pidfd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.setpoint  ($signed(s_tdata[23:0])),
		.measured  ($signed(s_tdata[47:24])),
		.now_us    (s_tdata[79:48]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.drive     (drive),
		.updated   (m_tuser[0])
	);

	assign m_tdata = drive;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives setpoint, measured and timestamp beats into the PID controller, with
// random idle cycles on both streams and one long output stall. Each result
// is checked against its directed row where one is given, else against a
// fixed-point controller model kept in step with every accepted beat. A short
// directed table precedes random gain and timeout phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned BEATS_PER_PHASE = 100;

	typedef struct {
		logic signed [23:0] sp;
		logic signed [23:0] mp;
		logic [31:0]        now;
		bit                 typed;
		logic signed [15:0] drive;
		logic               upd;
	} dir_row_t;

	typedef struct {
		logic [15:0] drive;
		logic        upd;
	} drive_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = pidfd_pkg::CFG_GAIN_P;
	logic [19:0] cfg_data = '0;

	drive_out_t  drive_fifo[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;

	// Controller model state and settings.
	int          kp, ki, kd;
	logic [19:0] gap_limit;
	logic [31:0] last_stamp;
	int          prev_err, err_sum, err_rate;

	pid_controller_filtered_derivative i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint round_div(input longint num, input longint den);
		if (num >= 0) begin
			return (num + den / 2) / den;
		end
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint gain_product(input int g, input int v);
		return clip32(round_div(longint'(g) * longint'(v), 256));
	endfunction

	function automatic drive_out_t control_step(input logic signed [23:0] sp,
			input logic signed [23:0] mp, input logic [31:0] now);
		drive_out_t r;
		logic [31:0] dt;
		longint err, acc, sum;
		dt = now - last_stamp;
		last_stamp = now;
		if (dt > {12'd0, gap_limit}) begin
			prev_err = 0;
			err_sum = 0;
			err_rate = 0;
			r.drive = '0;
			r.upd = 1'b0;
			return r;
		end
		err = longint'(sp) - longint'(mp);
		err_sum = int'(clip32(longint'(err_sum) + round_div(err * longint'(dt), 1000000)));
		acc = round_div(longint'(err_rate) * 4, 5);
		if (dt != 0) begin
			acc += round_div((err - longint'(prev_err)) * 200000, longint'(dt));
		end
		err_rate = int'(clip32(acc));
		sum = gain_product(kp, int'(err));
		sum = clip32(sum + gain_product(ki, err_sum));
		sum = clip32(sum + gain_product(kd, err_rate));
		if (sum > 25600) begin
			sum = 25600;
		end
		if (sum < -25600) begin
			sum = -25600;
		end
		prev_err = int'(err);
		r.drive = sum[15:0];
		r.upd = 1'b1;
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			pidfd_pkg::CFG_GAIN_P: kp = int'($signed(val[15:0]));
			pidfd_pkg::CFG_GAIN_I: ki = int'($signed(val[15:0]));
			pidfd_pkg::CFG_GAIN_D: kd = int'($signed(val[15:0]));
			pidfd_pkg::CFG_TIMEOUT: gap_limit = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_gains(input int p, input int i, input int d, input int unsigned lim);
		write_reg(pidfd_pkg::CFG_GAIN_P, {4'($urandom_range(0, 15)), 16'(p)});
		write_reg(pidfd_pkg::CFG_GAIN_I, {4'($urandom_range(0, 15)), 16'(i)});
		write_reg(pidfd_pkg::CFG_GAIN_D, {4'($urandom_range(0, 15)), 16'(d)});
		write_reg(pidfd_pkg::CFG_TIMEOUT, 20'(lim));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one beat, then records the expected result once it is taken.
	task automatic send_beat(input logic [23:0] sp, input logic [23:0] mp,
			input logic [31:0] now, input bit typed, input drive_out_t typed_out);
		drive_out_t r;
		while (!quiet && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, mp, sp};
		do begin
			@(posedge clk);
		end while (!s_tready);
		r = control_step(sp, mp, now);
		drive_fifo.push_back(typed ? typed_out : r);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (drive_fifo.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		drive_out_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (drive_fifo.size() == 0) begin
				$error("result with nothing expected: drive %0d updated %0b",
					$signed(m_tdata), m_tuser[0]);
				mismatches++;
			end else begin
				want = drive_fifo.pop_front();
				if (m_tdata !== want.drive) begin
					$error("drive: expected %0d, got %0d", $signed(want.drive),
						$signed(m_tdata));
					mismatches++;
				end
				if (m_tuser[0] !== want.upd) begin
					$error("updated: expected %0b, got %0b", want.upd, m_tuser[0]);
					mismatches++;
				end
			end
			if (results_seen == 40) begin
				hold_left = 3000;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 29);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t   rows[10];
		drive_out_t typed_out;
		logic [23:0] sp, mp;
		logic [31:0] now, dt;
		int unsigned pick;
		kp = 2560;
		ki = 0;
		kd = 0;
		gap_limit = 20'd20000;
		last_stamp = '0;
		prev_err = 0;
		err_sum = 0;
		err_rate = 0;
		rows = '{
			'{24'sd256, 24'sd0, 32'd100, 1'b1, 16'sd2560, 1'b1},
			'{24'sd8388607, -24'sd8388608, 32'd200, 1'b1, 16'sd25600, 1'b1},
			'{-24'sd8388608, 24'sd8388607, 32'd300, 1'b1, -16'sd25600, 1'b1},
			'{24'sd0, 24'sd0, 32'd300, 1'b1, 16'sd0, 1'b1},
			'{24'sd0, 24'sd0, 32'd100, 1'b1, 16'sd0, 1'b0},
			'{24'sd512, 24'sd256, 32'd20100, 1'b1, 16'sd2560, 1'b1},
			'{24'sd5, 24'sd0, 32'd40101, 1'b1, 16'sd0, 1'b0},
			'{24'sd0, 24'sd0, 32'hFFFFFFFF, 1'b1, 16'sd0, 1'b0},
			'{24'sd1000, -24'sd1000, 32'd20, 1'b0, 16'sd0, 1'b0},
			'{-24'sd7, 24'sd3, 32'd30, 1'b0, 16'sd0, 1'b0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[k]) begin
			typed_out.drive = rows[k].drive;
			typed_out.upd = rows[k].upd;
			send_beat(rows[k].sp, rows[k].mp, rows[k].now, rows[k].typed, typed_out);
		end
		now = 32'd30;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			quiet = (ph == 3);
			case (ph)
				0: set_gains(32767, 32767, 32767, 1000000);
				1: set_gains(-32768, -32768, -32768, 1);
				2: set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), 0);
				3: set_gains(2560, 0, 0, 20000);
				default: set_gains($urandom_range(0, 65535) - 32768,
					$urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128,
					$urandom_range(1, 1000000));
			endcase
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				sp = 24'($urandom);
				if ($urandom_range(0, 1) != 0) begin
					mp = sp + 24'($urandom_range(0, 2000)) - 24'd1000;
				end else begin
					mp = 24'($urandom);
				end
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					dt = '0;
				end else if (pick < 75) begin
					dt = $urandom_range(0, gap_limit);
				end else if (pick < 85) begin
					dt = {12'd0, gap_limit} + 32'd1 + $urandom_range(0, 1000);
				end else begin
					dt = $urandom;
				end
				now = now + dt;
				send_beat(sp, mp, now, 1'b0, typed_out);
			end
		end
		quiet = 1'b0;
		drain();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && drive_fifo.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
